>>> rtl/core/bpa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// block pool allocator. No dependencies.
package bpa_pkg;

   localparam int BLOCK_COUNT = 8;
   localparam int BLOCK_BYTES = 2097152;
   localparam int IDX_W       = $clog2(BLOCK_COUNT);
   localparam int LEN_W       = $clog2(BLOCK_COUNT + 1);

   typedef enum logic [1:0] {
      OP_ALLOC      = 2'd0,
      OP_REL_OFFSET = 2'd1,
      OP_REL_OWNER  = 2'd2,
      OP_NONE       = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_GRANTED  = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_RELEASED = 2'd2,
      STAT_NOMATCH  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ALLOC  = 4'b0010,
      ST_WALK   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request word, clear walk pointers
      logic alloc;    // pop free head onto used tail
      logic step;     // examine one used-list entry
      logic finish;   // commit walk, load response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic walk_done;
   } sts_type;

   function automatic logic [31:0] block_offset(input logic [IDX_W-1:0] idx);
      return 32'(idx) * 32'(BLOCK_BYTES);
   endfunction

endpackage

>>> rtl/core/bpa_ctrl.sv
// Sequencer for the block pool allocator: handshakes and walk control.
// Depends on bpa_pkg.
module bpa_ctrl
   import bpa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_opcode,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  sts_type    sts
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_opcode) inside
                  OP_ALLOC:                     state_in = ST_ALLOC;
                  OP_REL_OFFSET, OP_REL_OWNER: state_in = ST_WALK;
                  default:                      state_in = ST_FINISH;
               endcase
            end
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_WALK: begin
            if (sts.walk_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/bpa_datapath.sv
// Free stack, used list, owner tags, walk pointers and response register.
// Depends on bpa_pkg; driven by bpa_ctrl commands.
module bpa_datapath
   import bpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_owner_id,
   input  logic [31:0] req_release_offset,
   output logic [1:0]  rsp_status,
   output logic [23:0] rsp_granted_offset,
   output logic [3:0]  rsp_released_count,
   output logic [3:0]  rsp_free_count
);

   // free list kept as a stack: entry free_len-1 is the list head
   logic [IDX_W-1:0] stk_ff   [BLOCK_COUNT];
   logic [IDX_W-1:0] stk_in   [BLOCK_COUNT];
   logic [IDX_W-1:0] used_ff  [BLOCK_COUNT];
   logic [IDX_W-1:0] used_in  [BLOCK_COUNT];
   logic [31:0]      owner_ff [BLOCK_COUNT];
   logic [31:0]      owner_in [BLOCK_COUNT];

   logic [LEN_W-1:0] free_len_ff, free_len_in;
   logic [LEN_W-1:0] used_len_ff, used_len_in;
   logic [LEN_W-1:0] rd_ff, rd_in;
   logic [LEN_W-1:0] wr_ff, wr_in;
   logic [LEN_W-1:0] rel_cnt_ff, rel_cnt_in;
   logic [1:0]       op_ff, op_in;
   logic [31:0]      owner_id_ff, owner_id_in;
   logic [31:0]      offset_ff, offset_in;
   logic             grant_ok_ff, grant_ok_in;
   logic [IDX_W-1:0] grant_blk_ff, grant_blk_in;

   logic [1:0]       status_ff, status_in;
   logic [23:0]      goff_ff, goff_in;
   logic [3:0]       rcnt_ff, rcnt_in;
   logic [3:0]       fcnt_ff, fcnt_in;

   logic [IDX_W-1:0] walk_blk;
   logic [IDX_W-1:0] head_blk;
   logic             hit;

   assign walk_blk = used_ff[rd_ff[IDX_W-1:0]];
   assign head_blk = stk_ff[IDX_W'(free_len_ff - 1'b1)];
   assign sts.walk_done = (rd_ff == used_len_ff);

   always_comb begin
      if (op_ff == OP_REL_OFFSET) begin
         hit = (rel_cnt_ff == '0) && (block_offset(walk_blk) == offset_ff);
      end else begin
         hit = (owner_ff[walk_blk] == owner_id_ff);
      end
   end

   always_comb begin
      stk_in       = stk_ff;
      used_in      = used_ff;
      owner_in     = owner_ff;
      free_len_in  = free_len_ff;
      used_len_in  = used_len_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      rel_cnt_in   = rel_cnt_ff;
      op_in        = op_ff;
      owner_id_in  = owner_id_ff;
      offset_in    = offset_ff;
      grant_ok_in  = grant_ok_ff;
      grant_blk_in = grant_blk_ff;
      status_in    = status_ff;
      goff_in      = goff_ff;
      rcnt_in      = rcnt_ff;
      fcnt_in      = fcnt_ff;

      if (cmd.load) begin
         op_in       = req_opcode;
         owner_id_in = req_owner_id;
         offset_in   = req_release_offset;
         rd_in       = '0;
         wr_in       = '0;
         rel_cnt_in  = '0;
         grant_ok_in = 1'b0;
      end

      if (cmd.alloc && (free_len_ff != '0)) begin
         free_len_in                           = free_len_ff - 1'b1;
         owner_in[head_blk]                    = owner_id_ff;
         used_in[used_len_ff[IDX_W-1:0]]       = head_blk;
         used_len_in                           = used_len_ff + 1'b1;
         grant_ok_in                           = 1'b1;
         grant_blk_in                          = head_blk;
      end

      // compacting walk: kept entries slide down to the write pointer
      if (cmd.step) begin
         rd_in = rd_ff + 1'b1;
         if (hit) begin
            stk_in[free_len_ff[IDX_W-1:0]] = walk_blk;
            free_len_in                    = free_len_ff + 1'b1;
            rel_cnt_in                     = rel_cnt_ff + 1'b1;
         end else begin
            used_in[wr_ff[IDX_W-1:0]] = walk_blk;
            wr_in                     = wr_ff + 1'b1;
         end
      end

      if (cmd.finish) begin
         goff_in = '0;
         rcnt_in = '0;
         fcnt_in = 4'(free_len_ff);
         case (op_ff) inside
            OP_ALLOC: begin
               status_in = grant_ok_ff ? STAT_GRANTED : STAT_EMPTY;
               if (grant_ok_ff) begin
                  goff_in = 24'(block_offset(grant_blk_ff));
               end
            end
            OP_REL_OFFSET, OP_REL_OWNER: begin
               used_len_in = wr_ff;
               rcnt_in     = 4'(rel_cnt_ff);
               status_in   = (rel_cnt_ff != '0) ? STAT_RELEASED : STAT_NOMATCH;
            end
            default: status_in = STAT_NOMATCH;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BLOCK_COUNT; i++) begin
            stk_ff[i] <= IDX_W'(BLOCK_COUNT - 1 - i);
         end
         free_len_ff <= LEN_W'(BLOCK_COUNT);
         used_len_ff <= '0;
         rd_ff       <= '0;
         wr_ff       <= '0;
         rel_cnt_ff  <= '0;
         op_ff       <= OP_NONE;
         grant_ok_ff <= 1'b0;
      end else begin
         stk_ff      <= stk_in;
         free_len_ff <= free_len_in;
         used_len_ff <= used_len_in;
         rd_ff       <= rd_in;
         wr_ff       <= wr_in;
         rel_cnt_ff  <= rel_cnt_in;
         op_ff       <= op_in;
         grant_ok_ff <= grant_ok_in;
      end
   end

   // payload: only entries of live used blocks are ever read
   always_ff @(posedge clock) begin
      used_ff      <= used_in;
      owner_ff     <= owner_in;
      owner_id_ff  <= owner_id_in;
      offset_ff    <= offset_in;
      grant_blk_ff <= grant_blk_in;
      status_ff    <= status_in;
      goff_ff      <= goff_in;
      rcnt_ff      <= rcnt_in;
      fcnt_ff      <= fcnt_in;
   end

   assign rsp_status         = status_ff;
   assign rsp_granted_offset = goff_ff;
   assign rsp_released_count = rcnt_ff;
   assign rsp_free_count     = fcnt_ff;

endmodule

>>> rtl/core/block_pool_allocator_top.sv
// Top level of the block pool allocator: sequencer plus datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath.
//
// Hands out fixed-size memory blocks (BLOCK_COUNT blocks of BLOCK_BYTES each)
// from a LIFO free list and keeps allocated blocks on a used list in
// allocation order, each tagged with a 32-bit owner. One request word in,
// exactly one response word out. Opcodes: allocate (pop free head, tag it,
// return its byte offset or "no free block"), release by offset (free the
// first used block at that offset) and release by owner (free every block of
// that owner, in used-list order). Freed blocks go to the free head, so a
// release followed by allocate hands back the last block freed. One request
// is handled at a time. An allocate passes through the alloc and finish
// states before its response word is loaded. A release walks the used list
// (up to BLOCK_COUNT entries), examining and compacting one entry per cycle,
// then goes to the finish state. Unused opcode 3 goes straight to the finish
// state and responds "nothing matched". The next request can be accepted at
// the edge after the response is loaded, even if that response is still
// stalled downstream. A stalled response only holds up the end of the
// following request. req_stall is high during reset. No init pass: the free
// list is valid straight out of reset.
module block_pool_allocator_top
   import bpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request word
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_owner_id,
   input  logic [31:0] req_release_offset,
   // response word
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [23:0] rsp_granted_offset,
   output logic [3:0]  rsp_released_count,
   output logic [3:0]  rsp_free_count
);

   cmd_type cmd;
   sts_type sts;

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   bpa_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_opcode),
      .req_owner_id       (req_owner_id),
      .req_release_offset (req_release_offset),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_released_count (rsp_released_count),
      .rsp_free_count     (rsp_free_count)
   );

endmodule

>>> rtl/core/bpa_checker.sv
// Port-level checks for block_pool_allocator_top, attached by bind.
// Depends on bpa_pkg.
module bpa_checker
   import bpa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_opcode,
   input logic [31:0] req_owner_id,
   input logic [31:0] req_release_offset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [23:0] rsp_granted_offset,
   input logic [3:0]  rsp_released_count,
   input logic [3:0]  rsp_free_count
);

   a_rst_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_offset) && $stable(rsp_free_count))
      else $error("stalled response changed");

   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_GRANTED) |-> rsp_granted_offset == '0)
      else $error("offset without grant");

   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_GRANTED || rsp_status == STAT_EMPTY
         || rsp_status == STAT_NOMATCH) |-> rsp_released_count == '0)
      else $error("release count on non-release response");

   a_rel_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_RELEASED) |-> rsp_released_count != '0)
      else $error("released with zero count");

endmodule

bind block_pool_allocator_top bpa_checker u_bpa_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for block_pool_allocator_top: directed and random requests
// against an in-bench model of the free and used block lists.
// Depends on bpa_pkg and the RTL under rtl/core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpa_pkg::*;

   // Fixed owner tags for the directed part
   localparam logic [31:0] OWN_A = 32'h1234_5678;
   localparam logic [31:0] OWN_B = 32'hA5A5_5A5A;
   localparam logic [31:0] OWN_C = 32'h0F0F_F0F0;
   localparam logic [31:0] OWN_ONES = 32'hFFFF_FFFF;
   localparam int RANDOM_WORDS = 1525;

   // One response word as the block should present it
   typedef struct {
      status_type  status;
      logic [23:0] offset;
      logic [3:0]  released;
      logic [3:0]  remaining;
   } reply_type;

   // Pool model plus the queue of responses still owed by the block.
   class alloc_scoreboard;
      logic [IDX_W-1:0] free_order[BLOCK_COUNT];
      logic [IDX_W-1:0] used_order[BLOCK_COUNT];
      logic [31:0]      owner_tag[BLOCK_COUNT];
      int               free_len;
      int               used_len;
      reply_type        pending[$];
      int               errors;
      int               checked;
      int               tally[4];
      int               most_freed;

      function new();
         for (int i = 0; i < BLOCK_COUNT; i++) begin
            free_order[i] = IDX_W'(i);
            used_order[i] = '0;
            owner_tag[i]  = '0;
         end
         free_len = BLOCK_COUNT;
         used_len = 0;
         errors = 0;
         checked = 0;
         most_freed = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      // Pull used entry pos out of the list; its block goes back on the free head.
      function void drop_used(int pos);
         logic [IDX_W-1:0] blk;
         blk = used_order[pos];
         for (int i = pos; i < used_len - 1; i++) used_order[i] = used_order[i + 1];
         used_len--;
         owner_tag[blk] = '0;
         if (free_len < BLOCK_COUNT) begin
            for (int i = free_len; i > 0; i--) free_order[i] = free_order[i - 1];
            free_order[0] = blk;
            free_len++;
         end
      endfunction

      function void note_request(opcode_type op, logic [31:0] owner, logic [31:0] off);
         reply_type        r;
         logic [IDX_W-1:0] blk;
         int               i;
         r.status   = STAT_NOMATCH;
         r.offset   = '0;
         r.released = '0;
         case (op)
            OP_ALLOC: begin
               if (free_len > 0 && used_len < BLOCK_COUNT) begin
                  blk = free_order[0];
                  for (i = 0; i < free_len - 1; i++) free_order[i] = free_order[i + 1];
                  free_len--;
                  owner_tag[blk] = owner;
                  used_order[used_len] = blk;
                  used_len++;
                  r.offset = 24'(64'(blk) * 64'(BLOCK_BYTES));
                  r.status = STAT_GRANTED;
               end else begin
                  r.status = STAT_EMPTY;
               end
            end
            OP_REL_OFFSET: begin
               for (i = 0; i < used_len; i++) begin
                  if (64'(used_order[i]) * 64'(BLOCK_BYTES) == 64'(off)) begin
                     drop_used(i);
                     r.released = 4'd1;
                     break;
                  end
               end
               r.status = (r.released != 0) ? STAT_RELEASED : STAT_NOMATCH;
            end
            OP_REL_OWNER: begin
               i = 0;
               while (i < used_len) begin
                  if (owner_tag[used_order[i]] == owner) begin
                     drop_used(i);
                     r.released++;
                  end else begin
                     i++;
                  end
               end
               r.status = (r.released != 0) ? STAT_RELEASED : STAT_NOMATCH;
            end
            default: ;
         endcase
         r.remaining = 4'(free_len);
         tally[r.status]++;
         if (int'(r.released) > most_freed) most_freed = int'(r.released);
         pending.push_back(r);
      endfunction

      task report(string msg);
         if (errors < 50) $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_reply(reply_type got);
         reply_type want;
         if (pending.size() == 0) begin
            report($sformatf("response word with nothing outstanding, status %0d",
                             got.status));
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.status !== want.status)
            report($sformatf("word %0d status %0d, want %0d", checked, got.status,
                             want.status));
         if (got.offset !== want.offset)
            report($sformatf("word %0d granted_offset %h, want %h", checked, got.offset,
                             want.offset));
         if (got.released !== want.released)
            report($sformatf("word %0d released_count %0d, want %0d", checked,
                             got.released, want.released));
         if (got.remaining !== want.remaining)
            report($sformatf("word %0d free_count %0d, want %0d", checked, got.remaining,
                             want.remaining));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [31:0] req_owner_id = '0;
   logic [31:0] req_release_offset = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [23:0] rsp_granted_offset;
   logic [3:0]  rsp_released_count;
   logic [3:0]  rsp_free_count;

   // Quiet stretches: while set, that side never idles
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   logic [31:0] owner_pool[4];

   alloc_scoreboard board = new();

   always #1 clock = ~clock;

   block_pool_allocator_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_owner_id       (req_owner_id),
      .req_release_offset (req_release_offset),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_released_count (rsp_released_count),
      .rsp_free_count     (rsp_free_count)
   );

   function automatic int pause_len(bit quiet);
      return quiet ? 0 : int'($urandom_range(0, 4));
   endfunction

   // Mostly tags from a small pool so that owners repeat and release-by-owner
   // finds several blocks; now and then a fresh random tag.
   function automatic logic [31:0] pick_owner();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return owner_pool[$urandom_range(0, 3)];
   endfunction

   // Drive one request word. Inputs move on the falling edge; acceptance is
   // judged on the rising edge from the values settled before it. valid gets
   // exactly one assignment per falling edge, so back-to-back words keep it high.
   task automatic send_word(opcode_type op, logic [31:0] owner, logic [31:0] off);
      int gap;
      gap = pause_len(req_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_owner_id       <= owner;
      req_release_offset <= off;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(op, owner, off);
   endtask

   // Response side: check each accepted word at the rising edge, then hold
   // stall high for a random pause before the next one.
   initial begin
      reply_type got;
      int        hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.status    = status_type'(rsp_status);
            got.offset    = rsp_granted_offset;
            got.released  = rsp_released_count;
            got.remaining = rsp_free_count;
            board.check_reply(got);
            hold = pause_len(rsp_quiet);
            if (board.checked % 40 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus
   initial begin
      int               counted;
      int               n;
      int               r;
      int               alloc_weight;
      logic [31:0]      off;
      logic [31:0]      owner;
      logic [IDX_W-1:0] pick;

      owner_pool[0] = '0;
      owner_pool[1] = OWN_ONES;
      owner_pool[2] = $urandom;
      owner_pool[3] = $urandom;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty used list, pool drained to empty, single and multiple
      // releases, misaligned and out-of-range offsets, the unused opcode, and
      // reuse of the most recently freed block.
      send_word(OP_REL_OWNER, '0, '0);
      send_word(OP_REL_OFFSET, OWN_ONES, '0);
      send_word(OP_NONE, OWN_ONES, OWN_ONES);
      send_word(OP_ALLOC, OWN_A, OWN_ONES);
      send_word(OP_ALLOC, '0, '0);
      send_word(OP_ALLOC, OWN_B, '0);
      send_word(OP_ALLOC, OWN_A, '0);
      send_word(OP_ALLOC, OWN_ONES, '0);
      send_word(OP_ALLOC, OWN_A, '0);
      send_word(OP_ALLOC, '0, '0);
      send_word(OP_ALLOC, OWN_B, '0);
      send_word(OP_ALLOC, OWN_C, '0);                        // pool empty
      send_word(OP_NONE, '0, 32'(BLOCK_BYTES));
      send_word(OP_REL_OFFSET, '0, 32'(3 * BLOCK_BYTES));
      send_word(OP_REL_OFFSET, '0, 32'(3 * BLOCK_BYTES));    // already free
      send_word(OP_REL_OFFSET, '0, OWN_ONES);
      send_word(OP_REL_OFFSET, '0, 32'(BLOCK_BYTES + 1));
      send_word(OP_REL_OFFSET, '0, 32'(9 * BLOCK_BYTES));    // aliases block 1 in 24 bits
      send_word(OP_REL_OWNER, OWN_A, '0);                    // two blocks at once
      send_word(OP_ALLOC, OWN_C, '0);                        // gets the last one freed
      send_word(OP_REL_OWNER, '0, '0);
      send_word(OP_REL_OWNER, OWN_ONES, '0);
      send_word(OP_REL_OWNER, OWN_B, '0);
      send_word(OP_REL_OWNER, OWN_C, '0);
      send_word(OP_REL_OWNER, OWN_A, '0);                    // nothing left

      // Random: phases lean toward filling or draining the pool so both the
      // full and the empty corners come up often.
      counted = 0;
      n = 0;
      alloc_weight = 45;
      while (counted < RANDOM_WORDS) begin
         if (n % 40 == 0) begin
            req_quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
               0: alloc_weight = 25;
               1: alloc_weight = 45;
               default: alloc_weight = 70;
            endcase
         end
         n++;
         r = $urandom_range(0, 99);
         if (r < 3) begin
            send_word(OP_NONE, $urandom, $urandom);
         end else begin
            if (r < 3 + alloc_weight) begin
               send_word(OP_ALLOC, pick_owner(), $urandom);
            end else if ($urandom_range(0, 2) != 0) begin
               r = $urandom_range(0, 99);
               if (r < 70 && board.used_len > 0) begin
                  pick = board.used_order[$urandom_range(0, board.used_len - 1)];
                  off = 32'(pick) * 32'(BLOCK_BYTES);
               end else if (r < 85) begin
                  off = $urandom_range(0, BLOCK_COUNT - 1) * 32'(BLOCK_BYTES);
               end else if (r < 92) begin
                  off = $urandom_range(BLOCK_COUNT, 2047) * 32'(BLOCK_BYTES);
               end else if (r < 96) begin
                  off = $urandom_range(0, BLOCK_COUNT - 1) * 32'(BLOCK_BYTES)
                        + $urandom_range(1, BLOCK_BYTES - 1);
               end else begin
                  off = $urandom;
               end
               send_word(OP_REL_OFFSET, $urandom, off);
            end else begin
               if ($urandom_range(0, 9) < 6 && board.used_len > 0) begin
                  pick = board.used_order[$urandom_range(0, board.used_len - 1)];
                  owner = board.owner_tag[pick];
               end else begin
                  owner = pick_owner();
               end
               send_word(OP_REL_OWNER, owner, $urandom);
            end
            counted++;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then give a stray extra word time to show up
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("covered %0d words: %0d grants, %0d pool-empty refusals, %0d releases,",
               board.checked, board.tally[STAT_GRANTED], board.tally[STAT_EMPTY],
               board.tally[STAT_RELEASED]);
      $display("%0d with nothing matched; up to %0d blocks freed by one word",
               board.tally[STAT_NOMATCH], board.most_freed);
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this
   initial begin
      #1_000_000;
      $display("timeout with %0d response words outstanding", board.pending.size());
      $display("FAILURE");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_ctrl.sv
rtl/core/bpa_datapath.sv
rtl/core/block_pool_allocator_top.sv
rtl/core/bpa_checker.sv
tb/tb_top.sv
